// File: hw/rtl/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial hash values, round functions and the command and
// status structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam logic [31:0] PAD_WORD = 32'h8000_0000;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
      32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

   // Source of the word written into the block buffer.
   typedef enum logic [1:0] {
      SRC_DATA, SRC_ZERO, SRC_LEN_HI, SRC_LEN_LO
   } word_src_type;

   typedef struct packed {
      logic         push;       // write one word into the buffer
      word_src_type src;
      logic         len_add;    // add the beat's byte count to the bit length
      logic         round_init; // load working variables from the hash
      logic         round_step; // run one compression round
      logic         hash_add;   // fold working variables into the hash
      logic         reset_msg;  // return hash and length to reset values
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] round;
      logic [3:0] fill;         // words held in the buffer
   } dp_status_type;

   function automatic logic [31:0] ror(input logic [31:0] x, input logic [4:0] n);
      ror = (x >> n) | (x << (6'd32 - {1'b0, n}));
   endfunction

   // Last word masked to its valid bytes with the pad byte appended; a full word is returned unchanged.
   function automatic logic [31:0] pad_last(input logic [31:0] d, input logic [2:0] n);
      logic [31:0] res;
      res = PAD_WORD;
      unique case (n)
         3'd0: res = PAD_WORD;
         3'd1: res = {d[31:24], 24'h800000};
         3'd2: res = {d[31:16], 16'h8000};
         3'd3: res = {d[31:8], 8'h80};
         default: res = d;
      endcase
      pad_last = res;
   endfunction

endpackage

// File: hw/rtl/sha_datapath.sv
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer used as a sliding message schedule, length counter, hash
// registers and one compression round per cycle.
// ----------------------------------------------------------------------------
module sha_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sha_pkg::dp_cmd_type    cmd,
   input  logic [31:0]            in_word,
   input  logic [2:0]             in_bytes,
   input  logic [2:0]             out_index,
   output sha_pkg::dp_status_type status,
   output logic [31:0]            hash_word
);
   import sha_pkg::*;

   logic [31:0] w_ff [16];
   logic [31:0] h_ff [8], h_in [8];
   logic [31:0] v_ff [8], v_in [8];
   logic [63:0] bits_ff, bits_in;
   logic [3:0]  fill_ff, fill_in;
   logic [5:0]  round_ff, round_in;
   logic [31:0] push_word, w_next, s0, s1, t1, t2;

   always_comb begin
      unique case (cmd.src)
         SRC_DATA:   push_word = in_word;
         SRC_ZERO:   push_word = '0;
         SRC_LEN_HI: push_word = bits_ff[63:32];
         default:    push_word = bits_ff[31:0];
      endcase
   end

   // Schedule word 16 positions ahead; the buffer shifts once per round.
   assign s0 = ror(w_ff[1], 5'd7) ^ ror(w_ff[1], 5'd18) ^ (w_ff[1] >> 3);
   assign s1 = ror(w_ff[14], 5'd17) ^ ror(w_ff[14], 5'd19) ^ (w_ff[14] >> 10);
   assign w_next = w_ff[0] + s0 + w_ff[9] + s1;

   assign t1 = v_ff[7] + (ror(v_ff[4], 5'd6) ^ ror(v_ff[4], 5'd11) ^ ror(v_ff[4], 5'd25))
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + ROUND_K[round_ff] + w_ff[0];
   assign t2 = (ror(v_ff[0], 5'd2) ^ ror(v_ff[0], 5'd13) ^ ror(v_ff[0], 5'd22))
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_comb begin
      bits_in  = bits_ff;
      fill_in  = fill_ff;
      round_in = round_ff;
      v_in     = v_ff;
      h_in     = h_ff;
      if (cmd.len_add) begin
         bits_in = bits_ff + {58'd0, in_bytes, 3'd0};
      end
      if (cmd.push) begin
         fill_in = fill_ff + 4'd1;
      end
      if (cmd.round_init) begin
         v_in     = h_ff;
         round_in = '0;
      end
      if (cmd.round_step) begin
         v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         round_in = round_ff + 6'd1;
      end
      if (cmd.hash_add) begin
         for (int i = 0; i < 8; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end
      if (cmd.reset_msg) begin
         h_in    = INIT_HASH;
         bits_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff     <= INIT_HASH;
         bits_ff  <= '0;
         fill_ff  <= '0;
         round_ff <= '0;
      end else begin
         h_ff     <= h_in;
         bits_ff  <= bits_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      if (cmd.push) begin
         w_ff[fill_ff] <= push_word;
      end else if (cmd.round_step) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= w_next;
      end
   end

   assign status.round = round_ff;
   assign status.fill  = fill_ff;
   assign hash_word    = h_ff[out_index];

endmodule

// File: hw/rtl/sha_control.sv
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences word pushes, padding, 64 rounds per block and the digest beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sha_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_byte_count,
   input  logic                   req_last,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [2:0]             out_index,
   output logic                   pad_sel,
   output sha_pkg::dp_cmd_type    cmd,
   input  sha_pkg::dp_status_type status
);
   import sha_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PADW  = 3'd1; // push the pad word after a full last word
   localparam logic [2:0] ST_ZERO  = 3'd2; // zero fill and length words
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_ADD   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       fin_ff, fin_in;   // in padding: digest follows the final block
   logic [2:0] idx_ff, idx_in;
   logic       acc;
   // Set once the high length word has gone into the buffer.
   logic       pad_done_ff, pad_done_in;
   // A full last word completed a block, so the pad word still has to follow.
   logic       pad_pend_ff, pad_pend_in;

   assign acc       = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign out_index = idx_ff;

   always_comb begin
      state_in    = state_ff;
      fin_in      = fin_ff;
      idx_in      = idx_ff;
      pad_pend_in = pad_pend_ff;
      cmd         = '0;
      cmd.src     = SRC_ZERO;
      pad_sel     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               cmd.push    = 1'b1;
               cmd.src     = SRC_DATA;
               cmd.len_add = 1'b1;
               if (req_last) begin
                  fin_in = 1'b1;
                  if (req_byte_count >= 3'd4) begin
                     state_in = ST_PADW;
                  end else begin
                     pad_sel  = 1'b1;
                     state_in = ST_ZERO;
                  end
                  if (status.fill == 4'd15) begin
                     state_in    = ST_ROUND;
                     pad_pend_in = (req_byte_count >= 3'd4);
                  end
               end else if (status.fill == 4'd15) begin
                  state_in = ST_ROUND;
               end
               cmd.round_init = (status.fill == 4'd15);
            end
         end
         ST_PADW: begin
            cmd.push    = 1'b1;
            cmd.src     = SRC_DATA;
            pad_sel     = 1'b1;
            pad_pend_in = 1'b0;
            state_in    = ST_ZERO;
            if (status.fill == 4'd15) begin
               cmd.round_init = 1'b1;
               state_in       = ST_ROUND;
            end
         end
         ST_ZERO: begin
            cmd.push = 1'b1;
            priority if (status.fill == 4'd14) cmd.src = SRC_LEN_HI;
            else if (status.fill == 4'd15 && pad_done_ff) cmd.src = SRC_LEN_LO;
            else cmd.src = SRC_ZERO;
            if (status.fill == 4'd15) begin
               cmd.round_init = 1'b1;
               state_in       = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (status.round == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.hash_add = 1'b1;
            priority if (!fin_ff) state_in = ST_IDLE;
            else if (pad_pend_ff) state_in = ST_PADW;
            else if (status.fill == 4'd0 && pad_done_ff) state_in = ST_OUT;
            else state_in = ST_ZERO;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.reset_msg = 1'b1;
                  fin_in        = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pad_done_in = pad_done_ff;
      if (state_ff == ST_ZERO && status.fill == 4'd14) pad_done_in = 1'b1;
      if (state_ff == ST_OUT) pad_done_in = 1'b0;
   end

   // A pad word landing at position 14 or 15 leaves no room for the length;
   // ST_ZERO then fills the remainder and a further block carries it.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fin_ff      <= 1'b0;
         idx_ff      <= '0;
         pad_done_ff <= 1'b0;
         pad_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fin_ff      <= fin_in;
         idx_ff      <= idx_in;
         pad_done_ff <= pad_done_in;
         pad_pend_ff <= pad_pend_in;
      end
   end

   `ASSERT_IMPLY(a_out_only_final, clock, reset, rsp_valid, fin_ff, "digest beat outside message end")
   `ASSERT_NEXT(a_round_ends, clock, reset, state_ff == ST_ROUND && status.round == 6'd63, state_ff == ST_ADD, "round count overrun")
   `ASSERT_NEXT(a_out_done, clock, reset, rsp_valid && !rsp_stall && idx_ff == 3'd7, state_ff == ST_IDLE && status.fill == 4'd0, "message state not cleared")

endmodule

// File: hw/rtl/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a word stream and returns the eight digest words per message.
// ----------------------------------------------------------------------------
// Channel | Direction | Ports
// req     | in        | req_valid, req_stall, req_data_word, req_byte_count, req_last
// rsp     | out       | rsp_valid, rsp_stall, rsp_digest_word, rsp_word_index,
//         |           | rsp_final_word
// A word that does not complete a block is accepted while idle; one completing a
// block also runs the compression rounds and then the hash add on the single
// shared round unit, and req_stall stays high meanwhile.
// A last word adds padding pushes, one or two blocks, and eight digest beats.
// Reset is synchronous; rsp_stall holds the current digest beat.
module sha256_stream_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_final_word
);
   import sha_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          pad_sel;
   logic [2:0]    out_index;
   logic [31:0]   dp_word;
   logic [31:0]   pad_word;
   logic [2:0]    bytes;

   // While stalled the only padded word pushed is the lone pad word that
   // follows a full last word.
   always_comb begin
      if (!req_stall) begin
         bytes = !req_last ? 3'd4 : ((req_byte_count > 3'd4) ? 3'd4 : req_byte_count);
         pad_word = pad_last(req_data_word, bytes);
      end else begin
         bytes = 3'd4;
         pad_word = PAD_WORD;
      end
      dp_word = pad_sel ? pad_word : req_data_word;
   end

   sha_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_byte_count, .req_last,
      .rsp_stall, .rsp_valid, .out_index, .pad_sel, .cmd, .status);

   sha_datapath u_dp (
      .clock, .reset, .cmd, .in_word(dp_word), .in_bytes(bytes),
      .out_index, .status, .hash_word(rsp_digest_word));

   assign rsp_word_index = out_index;
   assign rsp_final_word = (out_index == 3'd7);

endmodule
